@@ rtl/coordinate_packet_parser_top_assert.svh @@
// ----------------------------------------------------------------------------
// Coordinate packet parser assertion macros
// Concurrent check macros for the parser; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_PACKET_PARSER_TOP_ASSERT_SVH
`define COORDINATE_PACKET_PARSER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CPP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cpp: same-cycle check failed");
// next-cycle implication
`define CPP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cpp: next-cycle check failed");
`else
`define CPP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CPP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/cpp_pkg.sv @@
// ----------------------------------------------------------------------------
// Coordinate packet parser package
// Defaults, parser state codes, character codes and prefix tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

    localparam int CPP_COORD_WIDTH = 16;
    localparam int CPP_MAX_POINTS  = 4;

    localparam int NUM_KINDS = 6;

    localparam logic [3:0] ST_START = 4'd0;
    localparam logic [3:0] ST_BODY  = 4'd8;
    localparam logic [3:0] ST_SEEK  = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    localparam logic [2:0] PH_OPEN  = 3'd0;
    localparam logic [2:0] PH_X_PRE = 3'd1;
    localparam logic [2:0] PH_X_SGN = 3'd2;
    localparam logic [2:0] PH_X_DIG = 3'd3;
    localparam logic [2:0] PH_COMMA = 3'd4;
    localparam logic [2:0] PH_Y_PRE = 3'd5;
    localparam logic [2:0] PH_Y_SGN = 3'd6;
    localparam logic [2:0] PH_Y_DIG = 3'd7;

    localparam logic [2:0] KIND_ROI  = 3'd0;
    localparam logic [2:0] KIND_RECT = 3'd4;

    localparam logic EV_COORD  = 1'b0;
    localparam logic EV_STATUS = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic [55:0] kind_text(input logic [2:0] k);
        logic [55:0] t;
        case (k)
            3'd0:    t = {"@ROI:", 16'h0000};
            3'd1:    t = {"@RED:", 16'h0000};
            3'd2:    t = "@LASER:";
            3'd3:    t = {"@BLUE:", 8'h00};
            3'd4:    t = {"@RECT:", 8'h00};
            3'd5:    t = {"@LASER", 8'h00};
            default: t = 56'h0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] kind_char(input logic [2:0] k, input logic [2:0] p);
        logic [55:0] t;
        t = kind_text(k) << (8 * p);
        return t[55:48];
    endfunction

    function automatic logic [2:0] kind_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd5;
            3'd1:    n = 3'd5;
            3'd2:    n = 3'd7;
            3'd3:    n = 3'd6;
            3'd4:    n = 3'd6;
            3'd5:    n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

`default_nettype wire

@@ rtl/coordinate_packet_parser_top.sv @@
// ----------------------------------------------------------------------------
// Coordinate packet parser
// Parses prefixed "(x,y)" text packets byte by byte into coordinate and status events.
// ----------------------------------------------------------------------------
// Input stream: one packet character per transaction in s_tdata[7:0], s_tlast
// on the final byte. Output stream: one transaction per coordinate as it
// converts (m_tuser = 0), and one status transaction at packet end
// (m_tuser = 1, packet_ok in m_tdata). m_tlast marks the last transaction
// caused by one input byte.
// Path: a byte is held in the input register and parsed from there; its
// results are written into the result queue, which drives the master side.
// Throughput: one byte per cycle while the result queue has room. A byte
// that ends a number and the packet at once yields two transactions; the
// two-entry result queue drains them in order, and the parse stage waits
// only if the queue cannot take all results of the byte in hand.
// Reset: synchronous, active low; the parser returns to the start of a
// packet and both the input register and the result queue empty.
// Stall: while m_tready is low the queue holds its entries; once it has no
// room for the results of the byte in hand, s_tready falls and the input
// register holds that byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coordinate_packet_parser_top_assert.svh"

module coordinate_packet_parser_top
    import cpp_pkg::*;
#(
    parameter int COORD_WIDTH = CPP_COORD_WIDTH,
    parameter int MAX_POINTS  = CPP_MAX_POINTS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] data_byte
    input  wire logic                   s_tlast,   // end_of_packet
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // target[2:0], slot[4:3], axis[5], coord_value[COORD_WIDTH+5:6],
    // packet_ok[COORD_WIDTH+6], zero fill above
    output logic [((COORD_WIDTH+14)/8)*8-1:0] m_tdata,
    output logic [0:0]                  m_tuser,   // [0] event_kind
    output logic                        m_tlast    // last_of_run
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = ((COORD_WIDTH + 14) / 8) * 8;
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int AW  = CW + 4;

    localparam logic [AW-1:0] MAG_LIMIT = {{4{1'b0}}, 1'b1, {(CW-1){1'b0}}};
    localparam logic [AW-1:0] POS_LIMIT = {{5{1'b0}}, {(CW-1){1'b1}}};

    typedef struct packed {
        logic           kind;
        logic [2:0]     target;
        logic [1:0]     slot;
        logic           axis;
        logic [CW-1:0]  value;
        logic           ok;
        logic           last;
    } result_t;

    function automatic logic [PCW-1:0] points_needed(input logic [2:0] t);
        logic [PCW-1:0] n;
        if (t == KIND_ROI) begin
            n = PCW'(MAX_POINTS);
        end else if (t == KIND_RECT) begin
            n = PCW'(2);
        end else begin
            n = PCW'(1);
        end
        return n;
    endfunction

    function automatic logic [CW-1:0] add_digit(input logic [CW-1:0] acc,
                                                input logic [3:0] d);
        logic [AW-1:0] wide;
        logic [AW-1:0] sum;
        wide = {4'b0000, acc};
        sum  = (wide << 3) + (wide << 1) + {{(AW-4){1'b0}}, d};
        if (sum > MAG_LIMIT) begin
            sum = MAG_LIMIT;
        end
        return sum[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] finish_value(input logic [CW-1:0] mag,
                                                   input logic neg);
        logic [CW-1:0] v;
        if (neg) begin
            v = ~mag + CW'(1);
        end else if ({4'b0000, mag} > POS_LIMIT) begin
            v = POS_LIMIT[CW-1:0];
        end else begin
            v = mag;
        end
        return v;
    endfunction

    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           in_eop_reg;

    logic [3:0]     state_reg,  state_next;
    logic [5:0]     alive_reg,  alive_next;
    logic [2:0]     phase_reg,  phase_next;
    logic [2:0]     type_reg,   type_next;
    logic [PCW-1:0] count_reg,  count_next;
    logic [CW-1:0]  acc_reg,    acc_next;
    logic           neg_reg,    neg_next;
    logic           failed_reg, failed_next;

    result_t        q_reg [2];
    result_t        q0_next, q1_next;
    logic [1:0]     out_cnt_reg, out_cnt_next;

    logic           emit;
    logic           emit_axis;
    logic [1:0]     emit_slot;
    logic [CW-1:0]  emit_value;
    logic           status_ok;
    logic [2:0]     status_target;
    logic [5:0]     alive_hit;
    logic [2:0]     top;
    logic           top_found;
    logic [2:0]     pos;
    logic [7:0]     b;
    logic [PCW-1:0] count_inc;

    result_t        coord_res, status_res, r0, r1;
    logic [1:0]     n_res;
    logic [1:0]     free_slots;
    logic [1:0]     base;
    logic           pop;
    logic           proceed;

    always_comb begin
        b           = in_byte_reg;
        pos         = state_reg[2:0];
        state_next  = state_reg;
        alive_next  = alive_reg;
        phase_next  = phase_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        failed_next = failed_reg;
        emit        = 1'b0;
        emit_axis   = 1'b0;
        emit_slot   = count_reg[1:0];
        emit_value  = '0;
        alive_hit   = '0;
        top         = '0;
        top_found   = 1'b0;
        count_inc   = count_reg + PCW'(1);

        if (state_reg < ST_BODY) begin
            for (int c = 0; c < NUM_KINDS; c++) begin
                alive_hit[c] = alive_reg[c] &
                    !((kind_len(3'(c)) > pos) && (kind_char(3'(c), pos) != b));
            end
            for (int c = NUM_KINDS - 1; c >= 0; c--) begin
                if (alive_hit[c]) begin
                    top       = 3'(c);
                    top_found = 1'b1;
                end
            end
            alive_next = alive_hit;
            if (!top_found) begin
                state_next  = ST_FIN;
                failed_next = 1'b1;
            end else if (kind_len(top) <= pos) begin
                type_next = top;
                if (b == CH_OPEN) begin
                    state_next = ST_BODY;
                    phase_next = PH_X_PRE;
                end else begin
                    state_next  = ST_FIN;
                    failed_next = 1'b1;
                end
            end else if ({1'b0, kind_len(top)} == {1'b0, pos} + 4'd1) begin
                type_next  = top;
                state_next = ST_BODY;
                phase_next = PH_OPEN;
            end else begin
                state_next = state_reg + 4'd1;
            end
        end else begin
            case (state_reg)
                ST_SEEK: begin
                    if (b == CH_OPEN) begin
                        state_next = ST_BODY;
                        phase_next = PH_X_PRE;
                    end else if (b == CH_NUL) begin
                        state_next  = ST_FIN;
                        failed_next = 1'b1;
                    end
                end
                ST_BODY: begin
                    case (phase_reg)
                        PH_OPEN: begin
                            if (b == CH_OPEN) begin
                                phase_next = PH_X_PRE;
                            end else begin
                                state_next  = ST_FIN;
                                failed_next = 1'b1;
                            end
                        end
                        PH_COMMA: begin
                            if (b == CH_COMMA) begin
                                phase_next = PH_Y_PRE;
                            end else begin
                                state_next  = ST_FIN;
                                failed_next = 1'b1;
                            end
                        end
                        PH_X_PRE, PH_Y_PRE: begin
                            if (is_ws(b)) begin
                                phase_next = phase_reg;
                            end else if (b == CH_PLUS || b == CH_MINUS) begin
                                neg_next   = (b == CH_MINUS);
                                phase_next = phase_reg + 3'd1;
                            end else if (is_digit(b)) begin
                                acc_next   = add_digit(acc_reg, b[3:0]);
                                phase_next = phase_reg + 3'd2;
                            end else begin
                                state_next  = ST_FIN;
                                failed_next = 1'b1;
                            end
                        end
                        PH_X_SGN, PH_Y_SGN: begin
                            if (is_digit(b)) begin
                                acc_next   = add_digit(acc_reg, b[3:0]);
                                phase_next = phase_reg + 3'd1;
                            end else begin
                                state_next  = ST_FIN;
                                failed_next = 1'b1;
                            end
                        end
                        PH_X_DIG: begin
                            if (is_digit(b)) begin
                                acc_next = add_digit(acc_reg, b[3:0]);
                            end else begin
                                emit       = 1'b1;
                                emit_axis  = 1'b0;
                                emit_value = finish_value(acc_reg, neg_reg);
                                acc_next   = '0;
                                neg_next   = 1'b0;
                                if (b == CH_COMMA) begin
                                    phase_next = PH_Y_PRE;
                                end else begin
                                    phase_next  = PH_COMMA;
                                    state_next  = ST_FIN;
                                    failed_next = 1'b1;
                                end
                            end
                        end
                        PH_Y_DIG: begin
                            if (is_digit(b)) begin
                                acc_next = add_digit(acc_reg, b[3:0]);
                            end else begin
                                emit       = 1'b1;
                                emit_axis  = 1'b1;
                                emit_value = finish_value(acc_reg, neg_reg);
                                acc_next   = '0;
                                neg_next   = 1'b0;
                                count_next = count_inc;
                                if (count_inc >= points_needed(type_reg)) begin
                                    state_next = ST_FIN;
                                end else if (b == CH_OPEN) begin
                                    phase_next = PH_X_PRE;
                                end else if (b == CH_NUL) begin
                                    state_next  = ST_FIN;
                                    failed_next = 1'b1;
                                end else begin
                                    state_next = ST_SEEK;
                                end
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end

        // close a number that runs up to the packet end
        if (in_eop_reg && state_next == ST_BODY &&
            (phase_next == PH_X_DIG || phase_next == PH_Y_DIG)) begin
            emit       = 1'b1;
            emit_axis  = (phase_next == PH_Y_DIG);
            emit_slot  = count_next[1:0];
            emit_value = finish_value(acc_next, neg_next);
            acc_next   = '0;
            neg_next   = 1'b0;
            if (phase_next == PH_Y_DIG) begin
                count_next = count_next + PCW'(1);
                state_next = ST_FIN;
                if (count_next < points_needed(type_next)) begin
                    failed_next = 1'b1;
                end
            end else begin
                state_next  = ST_FIN;
                failed_next = 1'b1;
            end
        end

        status_ok     = (state_next == ST_FIN) && !failed_next;
        status_target = (state_next >= ST_BODY) ? type_next : 3'd0;

        if (in_eop_reg) begin
            state_next  = ST_START;
            alive_next  = '1;
            phase_next  = PH_OPEN;
            type_next   = '0;
            count_next  = '0;
            acc_next    = '0;
            neg_next    = 1'b0;
            failed_next = 1'b0;
        end
    end

    always_comb begin
        coord_res.kind   = EV_COORD;
        coord_res.target = type_reg;
        coord_res.slot   = emit_slot;
        coord_res.axis   = emit_axis;
        coord_res.value  = emit_value;
        coord_res.ok     = 1'b0;
        coord_res.last   = !in_eop_reg;

        status_res.kind   = EV_STATUS;
        status_res.target = status_target;
        status_res.slot   = 2'd0;
        status_res.axis   = 1'b0;
        status_res.value  = '0;
        status_res.ok     = status_ok;
        status_res.last   = 1'b1;

        r0 = emit ? coord_res : status_res;
        r1 = status_res;

        n_res      = {1'b0, emit} + {1'b0, in_eop_reg};
        pop        = m_tvalid && m_tready;
        free_slots = 2'd2 - out_cnt_reg + {1'b0, pop};
        proceed    = in_valid_reg && (n_res <= free_slots);
        base       = out_cnt_reg - {1'b0, pop};

        q0_next = pop ? q_reg[1] : q_reg[0];
        q1_next = q_reg[1];
        if (proceed) begin
            if (base == 2'd0) begin
                q0_next = r0;
                q1_next = r1;
            end else if (base == 2'd1) begin
                q1_next = r0;
            end
        end
        out_cnt_next = base + (proceed ? n_res : 2'd0);
    end

    assign s_tready = !in_valid_reg || proceed;

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_eop_reg  <= s_tlast;
        end
        q_reg[0] <= q0_next;
        q_reg[1] <= q1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_cnt_reg  <= 2'd0;
            state_reg    <= ST_START;
            alive_reg    <= '1;
            phase_reg    <= PH_OPEN;
            type_reg     <= '0;
            count_reg    <= '0;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            failed_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_cnt_reg <= out_cnt_next;
            if (proceed) begin
                state_reg  <= state_next;
                alive_reg  <= alive_next;
                phase_reg  <= phase_next;
                type_reg   <= type_next;
                count_reg  <= count_next;
                acc_reg    <= acc_next;
                neg_reg    <= neg_next;
                failed_reg <= failed_next;
            end
        end
    end

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;
    assign m_tdata  = DW'({q_reg[0].ok, q_reg[0].value, q_reg[0].axis,
                           q_reg[0].slot, q_reg[0].target});

    `CPP_ASSERT_IMP(a_queue_depth, aclk, aresetn, 1'b1, out_cnt_reg != 2'd3)
    `CPP_ASSERT_IMP(a_no_overfill, aclk, aresetn, proceed, base + n_res <= 2'd2)
    `CPP_ASSERT_NXT(a_packet_restart, aclk, aresetn, proceed && in_eop_reg,
                    state_reg == ST_START && alive_reg == 6'h3F && count_reg == '0)
    `CPP_ASSERT_NXT(a_fin_sticks, aclk, aresetn,
                    proceed && !in_eop_reg && state_reg == ST_FIN,
                    state_reg == ST_FIN && !emit)

endmodule

`default_nettype wire
